// File: sv/image_rotate_flip_engine_macros.svh
// Assertion macros for the image rotate/flip engine checker.
// Included by files that hold concurrent assertions; no dependencies.
`ifndef IMAGE_ROTATE_FLIP_ENGINE_MACROS_SVH
`define IMAGE_ROTATE_FLIP_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IRFE_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IRFE_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/irfe_pkg.sv
// Shared types, constants and helpers for the image rotate/flip engine.
// No dependencies; used by every module of the block except irfe_ram.
package irfe_pkg;

    localparam int MAX_DIM     = 256;
    localparam int PIXEL_BITS  = 32;
    localparam int PIX_W       = 32;
    localparam int STORE_W     = PIXEL_BITS;
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int DIM_W       = COORD_W + 1;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DIM_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_CW   = 2'd0,
        MODE_CCW  = 2'd1,
        MODE_HMIR = 2'd2,
        MODE_VMIR = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [DIM_W-1:0]   src_width;
        logic [DIM_W-1:0]   src_height;
    } cfg_t;

    // One store access handed from front to back.
    typedef struct packed {
        logic               is_read;
        logic [ADDR_W-1:0]  addr;
        logic [STORE_W-1:0] data;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } cmd_t;

    // Zero acts as one, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            res = DIM_W'(MAX_DIM);
        else
            res = v;
        return res;
    endfunction

endpackage

// File: sv/irfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module irfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/irfe_front.sv
// Front end: classifies accepted words, tracks load/emit position, maps addresses.
// Depends on irfe_pkg.
module irfe_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             opcode,
    input  logic [irfe_pkg::PIX_W-1:0]       pixel_in,
    input  irfe_pkg::cfg_t                   cfg,
    output logic                             push,
    output irfe_pkg::cmd_t                   cmd
);

    logic [irfe_pkg::DIM_W-1:0]   w, h, dw, dh;
    logic [irfe_pkg::CNT_W-1:0]   total;
    logic [irfe_pkg::COORD_W-1:0] r, c, sr, sc;
    logic [irfe_pkg::CNT_W-1:0]   idx;
    logic                         last, room, is_load, is_emit;

    logic [irfe_pkg::CNT_W-1:0]   load_count_reg, load_count_next;
    logic [irfe_pkg::COORD_W-1:0] emit_row_reg, emit_row_next;
    logic [irfe_pkg::COORD_W-1:0] emit_col_reg, emit_col_next;
    logic                         frame_full_reg, frame_full_next;

    always_comb
    begin
        w     = irfe_pkg::clamp_dim(cfg.src_width);
        h     = irfe_pkg::clamp_dim(cfg.src_height);
        total = irfe_pkg::CNT_W'(w) * irfe_pkg::CNT_W'(h);

        unique case (cfg.mode) inside
            irfe_pkg::MODE_CW, irfe_pkg::MODE_CCW:
            begin
                dw = h;
                dh = w;
            end
            default:
            begin
                dw = w;
                dh = h;
            end
        endcase

        // saturate a stale position if the size shrank mid-frame
        r = ({1'b0, emit_row_reg} < dh) ? emit_row_reg : irfe_pkg::COORD_W'(dh - 1'b1);
        c = ({1'b0, emit_col_reg} < dw) ? emit_col_reg : irfe_pkg::COORD_W'(dw - 1'b1);

        unique case (cfg.mode)
            irfe_pkg::MODE_CW:
            begin
                sr = irfe_pkg::COORD_W'(h - 1'b1 - {1'b0, c});
                sc = r;
            end
            irfe_pkg::MODE_CCW:
            begin
                sr = c;
                sc = irfe_pkg::COORD_W'(w - 1'b1 - {1'b0, r});
            end
            irfe_pkg::MODE_HMIR:
            begin
                sr = r;
                sc = irfe_pkg::COORD_W'(w - 1'b1 - {1'b0, c});
            end
            default:
            begin
                sr = irfe_pkg::COORD_W'(h - 1'b1 - {1'b0, r});
                sc = c;
            end
        endcase

        idx  = irfe_pkg::CNT_W'(sr) * irfe_pkg::CNT_W'(w) + irfe_pkg::CNT_W'(sc);
        last = ({1'b0, r} == dh - 1'b1) && ({1'b0, c} == dw - 1'b1);
        room = load_count_reg < total;

        is_load = accept && (opcode == irfe_pkg::OP_LOAD) && !frame_full_reg;
        is_emit = accept && (opcode == irfe_pkg::OP_EMIT) && frame_full_reg;

        load_count_next = load_count_reg;
        emit_row_next   = emit_row_reg;
        emit_col_next   = emit_col_reg;
        frame_full_next = frame_full_reg;

        if (is_load)
        begin
            if (room)
                load_count_next = load_count_reg + 1'b1;
            frame_full_next = (load_count_next >= total);
        end
        else if (is_emit)
        begin
            if (last)
            begin
                load_count_next = '0;
                emit_row_next   = '0;
                emit_col_next   = '0;
                frame_full_next = 1'b0;
            end
            else if ({1'b0, c} == dw - 1'b1)
            begin
                emit_col_next = '0;
                emit_row_next = r + 1'b1;
            end
            else
            begin
                emit_col_next = c + 1'b1;
                emit_row_next = r;
            end
        end

        push        = (is_load && room) || is_emit;
        cmd.is_read = is_emit;
        cmd.addr    = is_emit ? idx[irfe_pkg::ADDR_W-1:0]
                              : load_count_reg[irfe_pkg::ADDR_W-1:0];
        cmd.data    = irfe_pkg::STORE_W'(pixel_in);
        cmd.row     = r;
        cmd.col     = c;
        cmd.last    = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            emit_row_reg   <= '0;
            emit_col_reg   <= '0;
            frame_full_reg <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            emit_row_reg   <= emit_row_next;
            emit_col_reg   <= emit_col_next;
            frame_full_reg <= frame_full_next;
        end
    end

endmodule

// File: sv/irfe_queue.sv
// Short command queue between front and back ends.
// Depends on irfe_pkg.
module irfe_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  irfe_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output irfe_pkg::cmd_t  head,
    output logic            not_empty,
    output logic            full
);

    irfe_pkg::cmd_t              entries_reg [irfe_pkg::QUEUE_DEPTH];
    logic [irfe_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [irfe_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [irfe_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_push, do_pop;

    always_comb
    begin
        do_push = push && !full;
        do_pop  = pop && not_empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == irfe_pkg::QPTR_W'(irfe_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == irfe_pkg::QPTR_W'(irfe_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = entries_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == irfe_pkg::QCNT_W'(irfe_pkg::QUEUE_DEPTH));

endmodule

// File: sv/irfe_back.sv
// Back end: drains the queue into the frame store and presents read results.
// Depends on irfe_pkg and irfe_ram.
module irfe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  irfe_pkg::cmd_t                head,
    input  logic                          not_empty,
    output logic                          pop,
    output logic                          result_valid,
    output logic [irfe_pkg::PIX_W-1:0]    pixel_out,
    output logic [irfe_pkg::COORD_W-1:0]  out_row,
    output logic [irfe_pkg::COORD_W-1:0]  out_col,
    output logic                          frame_last
);

    logic                          we, re;
    logic [irfe_pkg::STORE_W-1:0]  rdata;
    logic                          result_valid_reg;
    logic [irfe_pkg::COORD_W-1:0]  row_reg, col_reg;
    logic                          last_reg;

    // never stalls: one store access per cycle
    assign pop = not_empty;
    assign we  = pop && !head.is_read;
    assign re  = pop && head.is_read;

    irfe_ram #(
        .WIDTH (irfe_pkg::STORE_W),
        .DEPTH (irfe_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (head.addr),
        .wdata (head.data),
        .re    (re),
        .raddr (head.addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= re;
    end

    // tags line up with the registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            row_reg  <= head.row;
            col_reg  <= head.col;
            last_reg <= head.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign pixel_out    = irfe_pkg::PIX_W'(rdata);
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign frame_last   = last_reg;

endmodule

// File: sv/image_rotate_flip_engine.sv
// Image rotate/flip engine top level: config registers, front end, queue, back end.
// Depends on irfe_pkg, irfe_front, irfe_queue, irfe_back (and irfe_ram below it).
// A result strobe follows its emit word through the queue and the registered store read.
// Throughput: one word per clock while busy is low, loads and emits alike; at most one store access per word.
// Reset (rst_n, async): counters, queue, config (mode 0, 256x256) clear; store is not
// cleared. Results cannot be stalled by the receiver and show for one cycle only.
module image_rotate_flip_engine (
    input  logic                              clk,
    input  logic                              rst_n,

    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic [irfe_pkg::PIX_W-1:0]        pixel_in,

    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [irfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irfe_pkg::CFG_DATA_W-1:0]   cfg_data,

    // results
    output logic                              result_valid,
    output logic [irfe_pkg::PIX_W-1:0]        pixel_out,
    output logic [irfe_pkg::COORD_W-1:0]      out_row,
    output logic [irfe_pkg::COORD_W-1:0]      out_col,
    output logic                              frame_last
);

    irfe_pkg::mode_t              mode_reg;
    logic [irfe_pkg::DIM_W-1:0]   src_width_reg;
    logic [irfe_pkg::DIM_W-1:0]   src_height_reg;
    irfe_pkg::cfg_t               cfg;

    logic                         accept;
    logic                         push, pop, not_empty, full;
    irfe_pkg::cmd_t               push_cmd, head;

    // Config is always writable; software writes only while the engine is idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= irfe_pkg::MODE_CW;
            src_width_reg  <= irfe_pkg::DIM_W'(irfe_pkg::MAX_DIM);
            src_height_reg <= irfe_pkg::DIM_W'(irfe_pkg::MAX_DIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                irfe_pkg::REG_MODE:       mode_reg       <= irfe_pkg::mode_t'(cfg_data[1:0]);
                irfe_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                irfe_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default:                  ;  // unmapped index: write dropped
            endcase
        end
    end

    always_comb
    begin
        cfg.mode       = mode_reg;
        cfg.src_width  = src_width_reg;
        cfg.src_height = src_height_reg;
    end

    // Busy only when the command queue is full. The back end drains one entry
    // per cycle, so in practice a word is taken every clock.
    assign busy   = full;
    assign accept = start && !busy;

    // Front end: load counter, emit raster position, source address mapping.
    irfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .opcode   (opcode),
        .pixel_in (pixel_in),
        .cfg      (cfg),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Writes and reads reach the store in acceptance order, so a frame's
    // reads always follow its writes.
    irfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    // Back end: frame store access and result presentation.
    irfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .not_empty    (not_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_last   (frame_last)
    );

endmodule

// File: sv/irfe_checker.sv
// Port-level checker for the image rotate/flip engine, bound to the top level.
// Depends on irfe_pkg and image_rotate_flip_engine_macros.svh.
`include "image_rotate_flip_engine_macros.svh"

module irfe_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic opcode,
    input logic result_valid,
    input logic frame_last
);

    // every result traces back to an accepted emit word
    `IRFE_ASSERT_IMP(a_result_from_emit, clk, rst_n, result_valid, $past(start && !busy && opcode == irfe_pkg::OP_EMIT, 2), "result without an emit request")

    // a load never produces a result
    `IRFE_ASSERT_IMP(a_load_silent, clk, rst_n, start && !busy && opcode == irfe_pkg::OP_LOAD, ##2 !result_valid, "load produced a result")

    // after the last pixel the frame is empty, so no result can follow directly
    `IRFE_ASSERT_NXT(a_gap_after_last, clk, rst_n, result_valid && frame_last, !result_valid, "result right after frame end")

endmodule

bind image_rotate_flip_engine irfe_checker u_checker (.*);

// File: tb/image_rotate_flip_engine_test.sv
// Self-checking bench for image_rotate_flip_engine: loads frames, emits them back
// under all four transforms and checks every pixel, coordinate and end-of-frame flag.
// Depends on irfe_pkg and the image_rotate_flip_engine RTL only.
module image_rotate_flip_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 has no register behind it: writes there must change nothing.
    localparam logic [irfe_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Cycles with no accepted word, config write or result before giving up.
    localparam int STALL_LIMIT = 1000;

    // One destination pixel as the block should present it.
    typedef struct {
        logic [irfe_pkg::PIX_W-1:0]   pix;
        logic [irfe_pkg::COORD_W-1:0] row;
        logic [irfe_pkg::COORD_W-1:0] col;
        logic                         last;
    } dst_pixel_t;

    // Frame-buffer predictor plus the queue of pixels still owed by the block.
    class frame_scoreboard;
        bit [irfe_pkg::STORE_W-1:0]  store [irfe_pkg::STORE_DEPTH];
        int                          loaded;
        int                          next_row;
        int                          next_col;
        bit                          full;
        irfe_pkg::mode_t             mode;
        bit [irfe_pkg::DIM_W-1:0]    width_reg;
        bit [irfe_pkg::DIM_W-1:0]    height_reg;
        dst_pixel_t                  owed[$];
        int                          errors;

        function new();
            loaded     = 0;
            next_row   = 0;
            next_col   = 0;
            full       = 1'b0;
            mode       = irfe_pkg::MODE_CW;
            width_reg  = irfe_pkg::DIM_W'(irfe_pkg::MAX_DIM);
            height_reg = irfe_pkg::DIM_W'(irfe_pkg::MAX_DIM);
            errors     = 0;
        endfunction

        // Zero behaves as one, oversize as MAX_DIM.
        function int dim_of(bit [irfe_pkg::DIM_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (raw > irfe_pkg::MAX_DIM)
                return irfe_pkg::MAX_DIM;
            return int'(raw);
        endfunction

        function int frame_size();
            return dim_of(width_reg) * dim_of(height_reg);
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void write_reg(logic [irfe_pkg::CFG_IDX_W-1:0] idx,
                                logic [irfe_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                irfe_pkg::REG_MODE:       mode = irfe_pkg::mode_t'(data[1:0]);
                irfe_pkg::REG_SRC_WIDTH:  width_reg = data;
                irfe_pkg::REG_SRC_HEIGHT: height_reg = data;
                default:                  ;
            endcase
        endfunction

        // Advance the frame state for one accepted word; queue a pixel if one is due.
        function void note_word(logic op, logic [irfe_pkg::PIX_W-1:0] pix);
            int         w;
            int         h;
            int         dw;
            int         dh;
            int         r;
            int         c;
            int         src;
            dst_pixel_t px;
            w = dim_of(width_reg);
            h = dim_of(height_reg);
            if (op == irfe_pkg::OP_LOAD)
            begin
                if (full)
                    return;
                if (loaded < w * h)
                begin
                    store[loaded] = pix;
                    loaded++;
                end
                if (loaded >= w * h)
                    full = 1'b1;
                return;
            end
            if (!full)
                return;
            if (mode == irfe_pkg::MODE_CW || mode == irfe_pkg::MODE_CCW)
            begin
                dw = h;
                dh = w;
            end
            else
            begin
                dw = w;
                dh = h;
            end
            r = (next_row < dh) ? next_row : dh - 1;
            c = (next_col < dw) ? next_col : dw - 1;
            case (mode)
                irfe_pkg::MODE_CW:   src = (h - 1 - c) * w + r;
                irfe_pkg::MODE_CCW:  src = c * w + (w - 1 - r);
                irfe_pkg::MODE_HMIR: src = r * w + (w - 1 - c);
                default:             src = (h - 1 - r) * w + c;
            endcase
            px.pix  = store[src];
            px.row  = irfe_pkg::COORD_W'(r);
            px.col  = irfe_pkg::COORD_W'(c);
            px.last = (r == dh - 1) && (c == dw - 1);
            owed.push_back(px);
            if (px.last)
            begin
                loaded   = 0;
                next_row = 0;
                next_col = 0;
                full     = 1'b0;
            end
            else if (c == dw - 1)
            begin
                next_col = 0;
                next_row = r + 1;
            end
            else
            begin
                next_col = c + 1;
                next_row = r;
            end
        endfunction

        task report(string what);
            errors++;
            $display("%0t ns mismatch: %s", $time, what);
        endtask

        task check_pixel(logic [irfe_pkg::PIX_W-1:0] pix, logic [irfe_pkg::COORD_W-1:0] row,
                         logic [irfe_pkg::COORD_W-1:0] col, logic last);
            dst_pixel_t px;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected pixel %h at (%0d,%0d)", pix, row, col));
                return;
            end
            px = owed.pop_front();
            if (pix !== px.pix)
                report($sformatf("pixel_out %h, want %h", pix, px.pix));
            if (row !== px.row)
                report($sformatf("out_row %0d, want %0d", row, px.row));
            if (col !== px.col)
                report($sformatf("out_col %0d, want %0d", col, px.col));
            if (last !== px.last)
                report($sformatf("frame_last %b, want %b", last, px.last));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            opcode;
    logic [irfe_pkg::PIX_W-1:0]      pixel_in;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [irfe_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [irfe_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            result_valid;
    logic [irfe_pkg::PIX_W-1:0]      pixel_out;
    logic [irfe_pkg::COORD_W-1:0]    out_row;
    logic [irfe_pkg::COORD_W-1:0]    out_col;
    logic                            frame_last;

    frame_scoreboard sb;

    // Handshake flags, registered at the rising edge and read by the drivers at
    // the following falling edge, so drivers never race the sampling edge.
    logic word_taken;
    logic cfg_taken;
    int   quiet_cycles;

    // Random idle bursts on the command side; cleared for the tail of the run.
    bit   idle_on;
    // Load and emit words that move a frame forward (stray words not counted).
    int   frame_words;

    image_rotate_flip_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .pixel_in     (pixel_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_last   (frame_last)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: everything the block takes or gives is seen here at the rising edge.
    // Results are checked before the word of the same edge is noted; a result always
    // belongs to an emit word accepted at an earlier edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_taken   <= 1'b0;
            cfg_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (result_valid)
                sb.check_pixel(pixel_out, out_row, out_col, frame_last);
            if (start && !busy)
                sb.note_word(opcode, pixel_in);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            word_taken   <= start && !busy;
            cfg_taken    <= cfg_valid && cfg_ready;
            quiet_cycles <= (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                            ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: the block stopped taking words or owes pixels it never sends.
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[image_rotate_flip_engine] ERROR");
        $finish;
    end

    // One command word; returns at the falling edge after it was taken.
    task automatic send_word(input logic op, input logic [irfe_pkg::PIX_W-1:0] pix);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            start = 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        start    = 1'b1;
        opcode   = op;
        pixel_in = pix;
        do @(negedge clk); while (!word_taken);
    endtask

    // Register write with the block quiet: no pixel owed, and then an idle wait for
    // loads still in the pipe, which produce nothing to wait for.
    task automatic write_reg_word(input logic [irfe_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [irfe_pkg::CFG_DATA_W-1:0] data);
        start = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid = 1'b0;
    endtask

    // Mostly tiny frames; zero now and then to exercise the acts-as-one rule.
    function automatic logic [irfe_pkg::CFG_DATA_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2)
            return '0;
        if (roll < 15)
            return irfe_pkg::CFG_DATA_W'($urandom_range(1, 5));
        return irfe_pkg::CFG_DATA_W'($urandom_range(6, 16));
    endfunction

    // Frame boundary: new mode (upper data bits random, ignored) and size.
    // A big frame has one side clamped to MAX_DIM and the other of one pixel.
    task automatic setup_frame(input bit big);
        logic [irfe_pkg::CFG_DATA_W-1:0] wide;
        logic [irfe_pkg::CFG_DATA_W-1:0] narrow;
        write_reg_word(irfe_pkg::REG_MODE, irfe_pkg::CFG_DATA_W'($urandom()));
        if (big)
        begin
            wide   = irfe_pkg::CFG_DATA_W'($urandom_range(irfe_pkg::MAX_DIM, 511));
            narrow = irfe_pkg::CFG_DATA_W'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg_word(irfe_pkg::REG_SRC_WIDTH, wide);
                write_reg_word(irfe_pkg::REG_SRC_HEIGHT, narrow);
            end
            else
            begin
                write_reg_word(irfe_pkg::REG_SRC_WIDTH, narrow);
                write_reg_word(irfe_pkg::REG_SRC_HEIGHT, wide);
            end
        end
        else
        begin
            write_reg_word(irfe_pkg::REG_SRC_WIDTH, pick_dim());
            write_reg_word(irfe_pkg::REG_SRC_HEIGHT, pick_dim());
        end
    endtask

    // Mid-frame change that never grows the frame: a new mode, or one side cut
    // down. Cutting while loading can leave the frame already full (next load is
    // dropped); cutting while emitting can push the position past the new edge.
    task automatic squeeze_frame();
        int cur;
        case ($urandom_range(0, 2))
            0: write_reg_word(irfe_pkg::REG_MODE, irfe_pkg::CFG_DATA_W'($urandom()));
            1:
            begin
                cur = sb.dim_of(sb.width_reg);
                write_reg_word(irfe_pkg::REG_SRC_WIDTH,
                               irfe_pkg::CFG_DATA_W'($urandom_range(0, cur)));
            end
            default:
            begin
                cur = sb.dim_of(sb.height_reg);
                write_reg_word(irfe_pkg::REG_SRC_HEIGHT,
                               irfe_pkg::CFG_DATA_W'($urandom_range(0, cur)));
            end
        endcase
    endtask

    // Load until the frame is full, then emit until it has all come out, with
    // stray words of the wrong kind mixed in and now and then a squeeze.
    task automatic run_frame(input bit may_squeeze);
        int step;
        int squeeze_step;
        step = 0;
        squeeze_step = -1;
        if (may_squeeze && $urandom_range(0, 5) == 0)
            squeeze_step = $urandom_range(0, 2 * sb.frame_size());
        while (!sb.full)
        begin
            if (step == squeeze_step)
                squeeze_frame();
            if ($urandom_range(0, 9) == 0)
                send_word(irfe_pkg::OP_EMIT, $urandom());
            else
            begin
                send_word(irfe_pkg::OP_LOAD, $urandom());
                frame_words++;
            end
            step++;
        end
        while (sb.full)
        begin
            if (step == squeeze_step)
                squeeze_frame();
            if ($urandom_range(0, 9) == 0)
                send_word(irfe_pkg::OP_LOAD, $urandom());
            else
            begin
                send_word(irfe_pkg::OP_EMIT, $urandom());
                frame_words++;
            end
            step++;
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = irfe_pkg::OP_LOAD;
        pixel_in    = '0;
        cfg_valid   = 1'b0;
        cfg_index   = irfe_pkg::REG_MODE;
        cfg_data    = '0;
        idle_on     = 1'b1;
        frame_words = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // Emit before anything is loaded: nothing comes back.
        send_word(irfe_pkg::OP_EMIT, 32'hFFFF_FFFF);
        // Write to the unused index must leave the registers alone.
        write_reg_word(REG_SPARE, 9'h1FF);
        // Mode with its upper data bits set; zero width and height act as 1x1.
        write_reg_word(irfe_pkg::REG_MODE, {7'h7F, irfe_pkg::MODE_CW});
        write_reg_word(irfe_pkg::REG_SRC_WIDTH, '0);
        write_reg_word(irfe_pkg::REG_SRC_HEIGHT, '0);
        send_word(irfe_pkg::OP_LOAD, 32'hFFFF_FFFF);
        send_word(irfe_pkg::OP_EMIT, 32'h0000_0000);

        // 3x2 counter-clockwise, a stray emit while loading and a stray load once the
        // frame is full.
        write_reg_word(irfe_pkg::REG_MODE, irfe_pkg::CFG_DATA_W'(irfe_pkg::MODE_CCW));
        write_reg_word(irfe_pkg::REG_SRC_WIDTH, 9'd3);
        write_reg_word(irfe_pkg::REG_SRC_HEIGHT, 9'd2);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_0000);
        send_word(irfe_pkg::OP_EMIT, 32'h1234_5678);
        send_word(irfe_pkg::OP_LOAD, 32'hFFFF_FFFF);
        send_word(irfe_pkg::OP_LOAD, 32'hA5A5_A5A5);
        send_word(irfe_pkg::OP_LOAD, 32'h5A5A_5A5A);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_0001);
        send_word(irfe_pkg::OP_LOAD, 32'h8000_0000);
        send_word(irfe_pkg::OP_LOAD, 32'hDEAD_BEEF);
        repeat (6) send_word(irfe_pkg::OP_EMIT, 32'h0000_0000);

        // Horizontal mirror, 2x2 cut to 2x1 after two loads: the frame is
        // already full, so the next load is dropped and only marks it full.
        write_reg_word(irfe_pkg::REG_MODE, irfe_pkg::CFG_DATA_W'(irfe_pkg::MODE_HMIR));
        write_reg_word(irfe_pkg::REG_SRC_WIDTH, 9'd2);
        write_reg_word(irfe_pkg::REG_SRC_HEIGHT, 9'd2);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_0011);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_0022);
        write_reg_word(irfe_pkg::REG_SRC_HEIGHT, 9'd1);
        send_word(irfe_pkg::OP_LOAD, 32'hFFFF_0000);
        repeat (2) send_word(irfe_pkg::OP_EMIT, 32'h0000_0000);

        // Vertical mirror, 2x2; width zeroed after one pixel out, so the next
        // column lies past the edge and is pulled back to the last one.
        write_reg_word(irfe_pkg::REG_MODE, irfe_pkg::CFG_DATA_W'(irfe_pkg::MODE_VMIR));
        write_reg_word(irfe_pkg::REG_SRC_WIDTH, 9'd2);
        write_reg_word(irfe_pkg::REG_SRC_HEIGHT, 9'd2);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_00A0);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_00A1);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_00B0);
        send_word(irfe_pkg::OP_LOAD, 32'h0000_00B1);
        send_word(irfe_pkg::OP_EMIT, 32'h0000_0000);
        write_reg_word(irfe_pkg::REG_SRC_WIDTH, '0);
        repeat (2) send_word(irfe_pkg::OP_EMIT, 32'h0000_0000);

        // ---- random part ----
        // One frame with a side of MAX_DIM so coordinates reach 255, then small ones
        // until the word budget is spent.
        setup_frame(1'b1);
        run_frame(1'b0);
        while (frame_words < 600)
        begin
            idle_on = (frame_words < 560) && ($urandom_range(0, 9) < 7);
            setup_frame(1'b0);
            run_frame(1'b1);
        end

        // Drain: every owed pixel, then a margin for anything unasked for.
        start = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[image_rotate_flip_engine] OK");
        else
            $display("[image_rotate_flip_engine] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/irfe_pkg.sv
sv/irfe_ram.sv
sv/irfe_front.sv
sv/irfe_queue.sv
sv/irfe_back.sv
sv/image_rotate_flip_engine.sv
sv/irfe_checker.sv
tb/image_rotate_flip_engine_test.sv
